// ----- sv/cqs_pkg.sv -----
// package for the circular queue with search
// types, codes and default constants shared by cqs_front, cqs_back and the top level
// depends on nothing
`default_nettype none

package cqs_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int RING_SIZE_RST = 16;
    localparam int CFG_W         = 5;
    localparam int DATA_W        = 32;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_SRCH = 2'd2,
        KIND_DUMP = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ENQ      = 3'd0,
        STAT_OVF      = 3'd1,
        STAT_DEQ      = 3'd2,
        STAT_UNF      = 3'd3,
        STAT_FOUND    = 3'd4,
        STAT_NOTFOUND = 3'd5,
        STAT_DUMP     = 3'd6,
        STAT_EMPTY    = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SRCH,
        ST_DUMP
    } state_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [DATA_W-1:0]  operand;
    } cmd_t;

endpackage

`default_nettype wire

// ----- sv/cqs_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// depends on nothing
`default_nettype none

module cqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/cqs_front.sv -----
// command front end: accepts transactions, decodes the command kind and
// holds them in a two-entry queue for the back end; uses cqs_pkg
`default_nettype none

module cqs_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [cqs_pkg::KIND_W-1:0]            kind,
    input  wire logic signed [cqs_pkg::DATA_W-1:0]     operand,
    output logic                                       cmd_valid,
    input  wire logic                                  cmd_ready,
    output cqs_pkg::cmd_t                              cmd
);
    import cqs_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in.kind    = kind_t'(kind);
        cmd_in.operand = operand;
    end

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cqs_back.sv -----
// command back end: ring pointers, ring storage, scan sequencer and output register
// uses cqs_pkg and cqs_ram
`default_nettype none

module cqs_back #(
    parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [cqs_pkg::CFG_W-1:0]             cfg_wr_data,
    input  wire logic                                  cmd_valid,
    output logic                                       cmd_ready,
    input  wire cqs_pkg::cmd_t                         cmd,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [cqs_pkg::STATUS_W-1:0]               status,
    output logic signed [cqs_pkg::DATA_W-1:0]          result_value,
    output logic                                       last
);
    import cqs_pkg::*;

    localparam int IW       = $clog2(DEPTH);
    localparam int SW       = $clog2(DEPTH + 1);
    localparam int RS_RESET = (RING_SIZE_RST > DEPTH) ? DEPTH : RING_SIZE_RST;

    state_t                   state_reg, state_next;
    logic [IW-1:0]            head_reg, head_next;
    logic [IW-1:0]            tail_reg, tail_next;
    logic [IW-1:0]            scan_reg, scan_next;
    logic [SW-1:0]            ring_size_reg, ring_size_next;
    logic signed [DATA_W-1:0] key_reg, key_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_last_reg;

    logic                     emit;
    status_t                  emit_status;
    logic signed [DATA_W-1:0] emit_value;
    logic                     emit_last;

    logic                     ram_wr_en, ram_rd_en;
    logic [IW-1:0]            ram_rd_addr;
    logic [DATA_W-1:0]        ram_rd_data;

    logic                     out_free, empty, full, hit, scan_end;
    logic [IW-1:0]            scan_wrap;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
                                               input logic [SW-1:0] size);
        logic [SW-1:0] inc;
        inc = SW'(idx) + SW'(1);
        wrap_inc = (inc >= size) ? '0 : idx + IW'(1);
    endfunction

    cqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (cmd.operand),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign empty     = (head_reg == tail_reg);
    assign full      = (head_reg == wrap_inc(tail_reg, ring_size_reg));
    assign scan_wrap = wrap_inc(scan_reg, ring_size_reg);
    assign scan_end  = (scan_wrap == tail_reg);
    assign hit       = ($signed(ram_rd_data) == key_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free && !empty)
                begin
                    unique case (cmd.kind)
                        KIND_DEQ:  state_next = ST_DEQ;
                        KIND_SRCH: state_next = ST_SRCH;
                        KIND_DUMP: state_next = ST_DUMP;
                        KIND_ENQ:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DEQ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH:
            begin
                if ((hit || scan_end) && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (scan_end && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_ready      = 1'b0;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_wrap;
        head_next      = head_reg;
        tail_next      = tail_reg;
        scan_next      = scan_reg;
        key_next       = key_reg;
        ring_size_next = ring_size_reg;
        emit           = 1'b0;
        emit_status    = STAT_ENQ;
        emit_value     = cmd.operand;
        emit_last      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = out_free;
                if (cmd_valid && out_free)
                begin
                    key_next    = cmd.operand;
                    ram_rd_addr = head_reg;
                    scan_next   = head_reg;
                    unique case (cmd.kind)
                        KIND_ENQ:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                emit_status = STAT_OVF;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                tail_next   = wrap_inc(tail_reg, ring_size_reg);
                                emit_status = STAT_ENQ;
                            end
                        end
                        KIND_DEQ:
                        begin
                            if (empty)
                            begin
                                emit        = 1'b1;
                                emit_status = STAT_UNF;
                                emit_value  = '0;
                            end
                            else
                            begin
                                ram_rd_en = 1'b1;
                            end
                        end
                        KIND_SRCH:
                        begin
                            if (empty)
                            begin
                                emit        = 1'b1;
                                emit_status = STAT_NOTFOUND;
                            end
                            else
                            begin
                                ram_rd_en = 1'b1;
                            end
                        end
                        KIND_DUMP:
                        begin
                            if (empty)
                            begin
                                emit        = 1'b1;
                                emit_status = STAT_EMPTY;
                                emit_value  = '0;
                            end
                            else
                            begin
                                ram_rd_en = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_DEQ:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = STAT_DEQ;
                    emit_value  = $signed(ram_rd_data);
                    head_next   = wrap_inc(head_reg, ring_size_reg);
                end
            end
            ST_SRCH:
            begin
                emit_value = key_reg;
                if (hit)
                begin
                    emit        = out_free;
                    emit_status = STAT_FOUND;
                end
                else if (scan_end)
                begin
                    emit        = out_free;
                    emit_status = STAT_NOTFOUND;
                end
                else
                begin
                    ram_rd_en = 1'b1;
                    scan_next = scan_wrap;
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = STAT_DUMP;
                    emit_value  = $signed(ram_rd_data);
                    emit_last   = scan_end;
                    if (!scan_end)
                    begin
                        ram_rd_en = 1'b1;
                        scan_next = scan_wrap;
                    end
                end
            end
        endcase

        // register write empties the ring
        if (cfg_wr_en)
        begin
            head_next = '0;
            tail_next = '0;
            if (cfg_wr_data < CFG_W'(2))
            begin
                ring_size_next = SW'(2);
            end
            else if (int'(cfg_wr_data) > DEPTH)
            begin
                ring_size_next = SW'(DEPTH);
            end
            else
            begin
                ring_size_next = SW'(cfg_wr_data);
            end
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            scan_reg      <= '0;
            ring_size_reg <= SW'(RS_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            scan_reg      <= scan_next;
            ring_size_reg <= ring_size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_value_reg  <= emit_value;
            out_last_reg   <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = out_value_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/circular_queue_with_search.sv -----
// top level of the circular queue with search
// instantiates cqs_front and cqs_back; uses cqs_pkg
`default_nettype none

// Ring-buffer queue of signed 32-bit values with enqueue, dequeue, search and
// dump commands. Writing ring_size (clamped to 2..DEPTH) empties the ring; the
// ring holds at most ring_size-1 values. Commands enter a two-entry queue and
// are executed in order by a back end that owns one ring RAM with a single
// read port and a registered read. Enqueue, overflow, underflow, and search
// or dump of an empty ring are answered from the idle state; dequeue first
// reads the head entry. Search compares entries from the head up to the first
// match or the tail; dump reads every stored value, giving one result per
// cycle while the output side keeps taking them. The output is a register;
// while a result waits there unaccepted the back end stalls, and the two-entry
// queue takes up to two more commands before intake stops.

module circular_queue_with_search #(
    parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [cqs_pkg::CFG_W-1:0]             cfg_wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [cqs_pkg::KIND_W-1:0]            kind,
    input  wire logic signed [cqs_pkg::DATA_W-1:0]     operand,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [cqs_pkg::STATUS_W-1:0]               status,
    output logic signed [cqs_pkg::DATA_W-1:0]          result_value,
    output logic                                       last
);
    import cqs_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    cqs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .operand   (operand),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    cqs_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_value (result_value),
        .last         (last)
    );

endmodule

`default_nettype wire

// ----- test/tb_circular_queue_with_search.sv -----
// testbench for circular_queue_with_search: directed table, then random phases
// checked against an in-bench ring model; depends on cqs_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_circular_queue_with_search;

    import cqs_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 40;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct {
        status_t                  st;
        logic signed [DATA_W-1:0] val;
        logic                     lst;
    } result_t;

    typedef struct {
        bit                       is_cfg;
        logic [CFG_W-1:0]         cfg_val;
        kind_t                    cmd;
        logic signed [DATA_W-1:0] opnd;
        bit                       typed;
        status_t                  st;
        logic signed [DATA_W-1:0] val;
    } row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_W-1:0]           cfg_wr_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [KIND_W-1:0]          kind;
    logic signed [DATA_W-1:0]   operand;
    logic                       out_valid;
    logic                       out_ready;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   result_value;
    logic                       last;

    // ring model
    logic signed [DATA_W-1:0]   ring_q [DEPTH_DEF];
    int unsigned                head_ix  = 0;
    int unsigned                tail_ix  = 0;
    int unsigned                ring_len = RING_SIZE_RST;

    result_t                    pending_q [$];
    result_t                    step_res [$];
    row_t                       dir_tab [$];

    int                         err_count     = 0;
    int                         snd_idle_pct  = 0;
    int                         rcv_stall_pct = 0;
    int                         hold_req_cnt  = 0;
    int                         hold_done_cnt = 0;

    circular_queue_with_search u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .operand      (operand),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_value (result_value),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("** circular_queue_with_search: FAILED **");
        $finish;
    end

    function automatic int unsigned next_ix(int unsigned i);
        return (i + 1 >= ring_len) ? 0 : i + 1;
    endfunction

    function automatic result_t mk_res(status_t st, logic signed [DATA_W-1:0] v, logic l);
        result_t r;
        r.st  = st;
        r.val = v;
        r.lst = l;
        return r;
    endfunction

    function automatic void set_ring_size(logic [CFG_W-1:0] v);
        ring_len = (v < 2) ? 2 : ((v > DEPTH_DEF) ? DEPTH_DEF : v);
        head_ix  = 0;
        tail_ix  = 0;
    endfunction

    // fills step_res with the results of one command and updates the ring
    function automatic void queue_step(kind_t k, logic signed [DATA_W-1:0] v);
        int unsigned ix;
        bit          hit;
        step_res.delete();
        case (k)
            KIND_ENQ:
            begin
                if (head_ix == next_ix(tail_ix))
                    step_res.push_back(mk_res(STAT_OVF, v, 1'b1));
                else
                begin
                    ring_q[tail_ix] = v;
                    tail_ix = next_ix(tail_ix);
                    step_res.push_back(mk_res(STAT_ENQ, v, 1'b1));
                end
            end
            KIND_DEQ:
            begin
                if (head_ix == tail_ix)
                    step_res.push_back(mk_res(STAT_UNF, '0, 1'b1));
                else
                begin
                    step_res.push_back(mk_res(STAT_DEQ, ring_q[head_ix], 1'b1));
                    head_ix = next_ix(head_ix);
                end
            end
            KIND_SRCH:
            begin
                hit = 1'b0;
                for (ix = head_ix; ix != tail_ix && !hit; ix = next_ix(ix))
                    if (ring_q[ix] == v)
                        hit = 1'b1;
                step_res.push_back(mk_res(hit ? STAT_FOUND : STAT_NOTFOUND, v, 1'b1));
            end
            default:
            begin
                if (head_ix == tail_ix)
                    step_res.push_back(mk_res(STAT_EMPTY, '0, 1'b1));
                else
                    for (ix = head_ix; ix != tail_ix; ix = next_ix(ix))
                        step_res.push_back(mk_res(STAT_DUMP, ring_q[ix],
                                                  next_ix(ix) == tail_ix));
            end
        endcase
    endfunction

    function automatic int unsigned ring_count();
        return (tail_ix + ring_len - head_ix) % ring_len;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        if ($urandom_range(3) == 0)
            return $urandom_range(7);
        return $urandom;
    endfunction

    // when the ring is not empty, half of the searches look for a value that is stored
    function automatic logic signed [DATA_W-1:0] search_value();
        int unsigned ix;
        int unsigned n;
        if (ring_count() == 0 || $urandom_range(1) == 0)
            return rand_value();
        ix = head_ix;
        n  = $urandom_range(ring_count() - 1);
        repeat (n) ix = next_ix(ix);
        return ring_q[ix];
    endfunction

    task automatic tab_cmd(kind_t k, logic signed [DATA_W-1:0] op);
        row_t r;
        r.is_cfg = 1'b0;
        r.cmd    = k;
        r.opnd   = op;
        r.typed  = 1'b0;
        dir_tab.push_back(r);
    endtask

    task automatic tab_chk(kind_t k, logic signed [DATA_W-1:0] op, status_t st,
                           logic signed [DATA_W-1:0] v);
        row_t r;
        r.is_cfg = 1'b0;
        r.cmd    = k;
        r.opnd   = op;
        r.typed  = 1'b1;
        r.st     = st;
        r.val    = v;
        dir_tab.push_back(r);
    endtask

    task automatic tab_cfg(logic [CFG_W-1:0] v);
        row_t r;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        dir_tab.push_back(r);
    endtask

    task automatic send_cmd(kind_t k, logic signed [DATA_W-1:0] op, bit typed,
                            status_t st, logic signed [DATA_W-1:0] v);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        operand  <= op;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        queue_step(k, op);
        if (typed)
        begin
            step_res.delete();
            step_res.push_back(mk_res(st, v, 1'b1));
        end
        foreach (step_res[i])
            pending_q.push_back(step_res[i]);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_q.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
        if (pending_q.size() != 0)
        begin
            err_count++;
            $display("%0d expected results never arrived", pending_q.size());
            pending_q.delete();
        end
    endtask

    task automatic write_ring_size(logic [CFG_W-1:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        set_ring_size(v);
    endtask

    task automatic run_phase(logic [CFG_W-1:0] cv, int snd, int rcv, int n, int enq_pct,
                             bit hold);
        kind_t                    k;
        logic signed [DATA_W-1:0] op;
        int                       r;
        write_ring_size(cv);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        if (hold)
            hold_req_cnt++;
        repeat (n)
        begin
            if ($urandom_range(99) < enq_pct)
            begin
                k  = KIND_ENQ;
                op = rand_value();
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 40)
                    k = KIND_DEQ;
                else if (r < 75)
                    k = KIND_SRCH;
                else
                    k = KIND_DUMP;
                op = (k == KIND_SRCH) ? search_value() : $urandom;
            end
            send_cmd(k, op, 1'b0, STAT_ENQ, '0);
        end
    endtask

    // receiver: random stalls, plus one long hold-off when requested
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req_cnt != hold_done_cnt)
            begin
                hold_done_cnt++;
                out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected transaction: status %0d value %h last %0b",
                             status, result_value, last);
            end
            else
            begin
                e = pending_q.pop_front();
                if (status !== e.st || result_value !== e.val || last !== e.lst)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected status %0d value %h last %0b, got %0d %h %0b",
                                 e.st, e.val, e.lst, status, result_value, last);
                end
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        kind        <= KIND_ENQ;
        operand     <= '0;

        tab_chk(KIND_DUMP, 32'sh0000_0000, STAT_EMPTY,    32'sh0000_0000);
        tab_chk(KIND_DEQ,  32'shffff_ffff, STAT_UNF,      32'sh0000_0000);
        tab_chk(KIND_SRCH, 32'sh0000_0005, STAT_NOTFOUND, 32'sh0000_0005);
        tab_chk(KIND_ENQ,  32'sh7fff_ffff, STAT_ENQ,      32'sh7fff_ffff);
        tab_chk(KIND_ENQ,  32'sh8000_0000, STAT_ENQ,      32'sh8000_0000);
        tab_chk(KIND_ENQ,  32'sh0000_0000, STAT_ENQ,      32'sh0000_0000);
        tab_chk(KIND_ENQ,  32'shffff_ffff, STAT_ENQ,      32'shffff_ffff);
        tab_chk(KIND_SRCH, 32'sh8000_0000, STAT_FOUND,    32'sh8000_0000);
        tab_chk(KIND_SRCH, 32'shffff_ffff, STAT_FOUND,    32'shffff_ffff);
        tab_cmd(KIND_SRCH, 32'sh0001_2345);
        tab_cmd(KIND_DUMP, 32'sh0000_0000);
        tab_chk(KIND_DEQ,  32'sh0000_0000, STAT_DEQ,      32'sh7fff_ffff);
        // size below range acts as 2 and empties the ring
        tab_cfg(5'd0);
        tab_chk(KIND_DEQ,  32'sh0000_0000, STAT_UNF,      32'sh0000_0000);
        tab_chk(KIND_ENQ,  32'sh55aa_55aa, STAT_ENQ,      32'sh55aa_55aa);
        tab_chk(KIND_ENQ,  32'shaa55_aa55, STAT_OVF,      32'shaa55_aa55);
        tab_chk(KIND_DUMP, 32'sh0000_0000, STAT_DUMP,     32'sh55aa_55aa);
        tab_chk(KIND_DEQ,  32'sh0000_0000, STAT_DEQ,      32'sh55aa_55aa);
        tab_cmd(KIND_ENQ,  32'shaa55_aa55);
        tab_cmd(KIND_SRCH, 32'shaa55_aa55);
        tab_cmd(KIND_DEQ,  32'sh0000_0000);
        // size above range acts as the full depth
        tab_cfg(5'd31);
        tab_cmd(KIND_ENQ,  32'sh0000_0001);
        tab_cmd(KIND_ENQ,  32'sh0000_0002);
        tab_cmd(KIND_SRCH, 32'sh0000_0002);
        tab_cmd(KIND_DUMP, 32'sh0000_0000);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                write_ring_size(dir_tab[i].cfg_val);
            else
                send_cmd(dir_tab[i].cmd, dir_tab[i].opnd, dir_tab[i].typed,
                         dir_tab[i].st, dir_tab[i].val);
        end

        run_phase(5'd16, 0,  0,  30, 60, 1'b1);
        run_phase(5'd2,  69, 0,  20, 45, 1'b0);
        run_phase(5'd5,  0,  69, 30, 50, 1'b0);
        run_phase(5'd31, 12, 12, 35, 75, 1'b0);
        run_phase(5'd1,  0,  0,  15, 45, 1'b0);
        run_phase(5'd9,  69, 0,  30, 55, 1'b0);
        run_phase(5'd17, 0,  69, 30, 70, 1'b0);
        run_phase(5'd3,  12, 12, 30, 45, 1'b0);

        wait_idle();
        if (err_count == 0)
            $display("** circular_queue_with_search: PASSED **");
        else
            $display("** circular_queue_with_search: FAILED **");
        $finish;
    end

endmodule
